@@ rtl/contiguous_weight_partitioner_defines.svh @@
// Assertion macros for the partitioner checker.
// Both macros assume clk_i and rst_ni are visible where they are used.
`ifndef CONTIGUOUS_WEIGHT_PARTITIONER_DEFINES_SVH
`define CONTIGUOUS_WEIGHT_PARTITIONER_DEFINES_SVH

// Concurrent property, clocked on clk_i, off during reset.
`define CWP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cwp check failed");

// Condition in one cycle implies a consequence in the next.
`define CWP_ASSERT_NEXT(lbl, cond, conseq) \
  `CWP_ASSERT(lbl, (cond) |=> (conseq))

`endif

@@ rtl/cwp_pkg.sv @@
// ----------------------------------------------------------------------------
// cwp_pkg
// Shared constants for the contiguous weight partitioner: default sizes,
// fixed port widths, register indexes and status codes.
// ----------------------------------------------------------------------------
package cwp_pkg;

  localparam int MAX_CELLS_DEF   = 1024;
  localparam int MAX_PARTS_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed port widths
  localparam int WEIGHT_W   = 16;
  localparam int PCOUNT_W   = 7;
  localparam int MINC_W     = 11;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int PIDX_W     = 6;
  localparam int CELL_W     = 11;
  localparam int LOAD_W     = 26;
  localparam int IMB_W      = 16;
  localparam int STATUS_W   = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CELLS  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DIM  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Imbalance special values, Q8.8
  localparam logic [IMB_W-1:0] IMB_ONE = 16'h0100;
  localparam logic [IMB_W-1:0] IMB_SAT = 16'hFFFF;

endpackage

@@ rtl/contiguous_weight_partitioner.sv @@
// ----------------------------------------------------------------------------
// contiguous_weight_partitioner
// Splits a run of cell weights into contiguous parts of balanced load.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one cell weight per word;
//   the word with last_i set ends the run. Weights are taken one per cycle
//   while idle. After the last word in_stall_o stays high while the block
//   checks the dimensions, places each inner boundary by a linear scan of
//   the prefix store (a fetch and a compare per cell scanned, one memory
//   read port), then runs a restoring divider for the imbalance unless it
//   saturates (zero-total: one divide per inner boundary, imbalance one).
//   Output channel (out_valid_o / out_stall_i) then gives one word per part,
//   via the read, load and output states, final_res_o on the last. An error
//   run gives a single word. The output word holds while out_stall_i is high
//   and no new weight is taken until the run's last word has gone.
//   Reset: part_count 1, min_cells_per_part 1, no cells stored. The prefix
//   and part stores need no clearing.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i;
//   the user must write it only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module contiguous_weight_partitioner
  import cwp_pkg::*;
#(
  parameter int MAX_CELLS   = MAX_CELLS_DEF,
  parameter int MAX_PARTS   = MAX_PARTS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WEIGHT_W-1:0]  weight_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIDX_W-1:0]    part_index_o,
  output logic [CELL_W-1:0]    first_cell_o,
  output logic [CELL_W-1:0]    end_cell_o,
  output logic [LOAD_W-1:0]    part_load_o,
  output logic [IMB_W-1:0]     imbalance_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 final_res_o
);

  localparam int CW  = $clog2(MAX_CELLS + 1);
  localparam int PCW = $clog2(MAX_PARTS + 1);
  localparam int PAW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int PW  = WEIGHT_BITS + CW;
  localparam int XW  = PW + PCW;
  localparam int DW  = XW + 8;
  localparam int MW  = PCW + MINC_W;
  localparam int RW  = 2 * CW + PW;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SETUP, S_FETCH, S_CMP, S_ZDIV, S_REC,
    S_IMB, S_IMB2, S_IMBW, S_ERD, S_ELD, S_EOUT
  } state_e;

  state_e state_q;

  logic [PCOUNT_W-1:0] part_count_q;
  logic [MINC_W-1:0]   min_cells_q;
  logic [CW-1:0]       cnt_q, prev_q, lo_q, hi_q, sel_q, b_q;
  logic [PW-1:0]       acc_q, peak_q, prevpre_q, ppre_q, bp_q, rd_q;
  logic [XW-1:0]       tgt_q, pprod_q, num_q;
  logic [PCW-1:0]      part_q, k_q;
  logic                ovf_q;
  logic [DW-1:0]       div_a_q, div_b_q;
  logic                div_start_q, div_done;
  logic [DW-1:0]       div_quot;
  logic [RW-1:0]       prec_q;

  logic [PW-1:0]  pre_mem [0:MAX_CELLS];
  logic [RW-1:0]  part_mem [0:MAX_PARTS-1];

  logic                   accept;
  logic [31:0]            wext;
  logic [PW-1:0]          w;
  logic                   room;
  logic [PCW-1:0]         pc;
  logic [XW-1:0]          prod;
  logic [MW-1:0]          pm, rem_mul;
  logic                   bad_dim;
  logic [CW:0]            zsum;
  logic [PW-1:0]          rec_load;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign wext       = 32'(weight_i);
  assign w          = PW'(wext[WEIGHT_BITS-1:0]);
  assign room       = 32'(cnt_q) < MAX_CELLS;
  assign pc         = PCW'(part_count_q);
  assign prod       = XW'(rd_q) * XW'(pc);
  assign pm         = MW'(part_count_q) * MW'(min_cells_q);
  assign rem_mul    = MW'(pc - part_q) * MW'(min_cells_q);
  assign bad_dim    = (part_count_q == '0) || (32'(part_count_q) > MAX_PARTS) ||
                      (min_cells_q == '0) || (32'(cnt_q) < 32'(pm));
  assign zsum       = {1'b0, prev_q} + (CW + 1)'(div_quot);
  assign rec_load   = bp_q - prevpre_q;

  cwp_div #(.W(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // prefix store: entry i holds the sum of the first i weights
  always_ff @(posedge clk_i) begin
    if (accept && room) begin
      pre_mem[CW'(cnt_q + 1'b1)] <= acc_q + w;
    end
    rd_q <= pre_mem[sel_q];
  end

  // part records {first, end, load}
  always_ff @(posedge clk_i) begin
    if (state_q == S_REC) begin
      part_mem[PAW'(part_q - 1'b1)] <= {prev_q, b_q, rec_load};
    end
    prec_q <= part_mem[PAW'(k_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      part_count_q <= PCOUNT_W'(1);
      min_cells_q  <= MINC_W'(1);
      cnt_q        <= '0;
      acc_q        <= '0;
      ovf_q        <= 1'b0;
      peak_q       <= '0;
      out_valid_o  <= 1'b0;
      div_start_q  <= 1'b0;
      part_q       <= '0;
      k_q          <= '0;
      sel_q        <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_PART_COUNT) part_count_q <= cfg_data_i[PCOUNT_W-1:0];
        else                             min_cells_q  <= cfg_data_i[MINC_W-1:0];
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (room) begin
              acc_q <= acc_q + w;
              cnt_q <= cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_i) state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ovf_q || bad_dim) begin
            part_index_o <= '0;
            first_cell_o <= '0;
            end_cell_o   <= '0;
            part_load_o  <= '0;
            imbalance_o  <= '0;
            status_o     <= ovf_q ? STATUS_OVERFLOW : STATUS_BAD_DIM;
            final_res_o  <= 1'b1;
            out_valid_o  <= 1'b1;
            state_q      <= S_EOUT;
          end else begin
            prev_q    <= '0;
            prevpre_q <= '0;
            peak_q    <= '0;
            part_q    <= PCW'(1);
            tgt_q     <= XW'(acc_q);
            if (pc == PCW'(1)) begin
              b_q     <= cnt_q;
              bp_q    <= acc_q;
              state_q <= S_REC;
            end else begin
              state_q <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          lo_q  <= CW'(32'(prev_q) + 32'(min_cells_q));
          sel_q <= CW'(32'(prev_q) + 32'(min_cells_q));
          hi_q  <= CW'(32'(cnt_q) - 32'(rem_mul));
          if (acc_q == '0) begin
            div_a_q     <= DW'(cnt_q - prev_q);
            div_b_q     <= DW'({1'b0, pc} - {1'b0, part_q} + 1'b1);
            div_start_q <= 1'b1;
            state_q     <= S_ZDIV;
          end else begin
            state_q <= S_FETCH;
          end
        end
        S_FETCH: state_q <= S_CMP;
        S_CMP: begin
          if (sel_q <= hi_q && prod < tgt_q) begin
            pprod_q <= prod;
            ppre_q  <= rd_q;
            sel_q   <= sel_q + 1'b1;
            state_q <= S_FETCH;
          end else begin
            state_q <= S_REC;
            if (sel_q > hi_q) begin
              // scan ran past the window: clamp to its top
              b_q  <= hi_q;
              bp_q <= ppre_q;
            end else if (sel_q > lo_q && (tgt_q - pprod_q) <= (prod - tgt_q)) begin
              b_q  <= sel_q - 1'b1;
              bp_q <= ppre_q;
            end else begin
              b_q  <= sel_q;
              bp_q <= rd_q;
            end
          end
        end
        S_ZDIV: begin
          if (div_done) begin
            if (zsum < {1'b0, lo_q})      b_q <= lo_q;
            else if (zsum > {1'b0, hi_q}) b_q <= hi_q;
            else                          b_q <= zsum[CW-1:0];
            bp_q    <= '0;
            state_q <= S_REC;
          end
        end
        S_REC: begin
          if (rec_load > peak_q) peak_q <= rec_load;
          prev_q    <= b_q;
          prevpre_q <= bp_q;
          if (part_q == pc) begin
            state_q <= S_IMB;
          end else begin
            part_q <= part_q + 1'b1;
            tgt_q  <= tgt_q + XW'(acc_q);
            if (part_q + 1'b1 == pc) begin
              b_q     <= cnt_q;
              bp_q    <= acc_q;
              state_q <= S_REC;
            end else begin
              state_q <= S_SETUP;
            end
          end
        end
        S_IMB: begin
          k_q <= '0;
          if (acc_q == '0) begin
            imbalance_o <= IMB_ONE;
            state_q     <= S_ERD;
          end else begin
            num_q   <= XW'(peak_q) * XW'(pc);
            state_q <= S_IMB2;
          end
        end
        S_IMB2: begin
          // quotient of 256 or more saturates
          if (num_q >= (XW'(acc_q) << 8)) begin
            imbalance_o <= IMB_SAT;
            state_q     <= S_ERD;
          end else begin
            div_a_q     <= {num_q, 8'h00};
            div_b_q     <= DW'(acc_q);
            div_start_q <= 1'b1;
            state_q     <= S_IMBW;
          end
        end
        S_IMBW: begin
          if (div_done) begin
            imbalance_o <= div_quot[IMB_W-1:0];
            state_q     <= S_ERD;
          end
        end
        S_ERD: state_q <= S_ELD;
        S_ELD: begin
          part_index_o <= PIDX_W'(k_q);
          first_cell_o <= CELL_W'(prec_q[RW-1 -: CW]);
          end_cell_o   <= CELL_W'(prec_q[PW +: CW]);
          part_load_o  <= LOAD_W'(prec_q[PW-1:0]);
          status_o     <= STATUS_OK;
          final_res_o  <= (k_q + 1'b1 == pc);
          out_valid_o  <= 1'b1;
          state_q      <= S_EOUT;
        end
        S_EOUT: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            if (final_res_o) begin
              cnt_q   <= '0;
              acc_q   <= '0;
              ovf_q   <= 1'b0;
              peak_q  <= '0;
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_ERD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/cwp_div.sv @@
// ----------------------------------------------------------------------------
// cwp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cwp_div #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_q, quot_q, div_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [W:0]       shifted;
  logic             ge;

  assign shifted = {rem_q, quot_q[W-1]};
  assign ge      = shifted >= {1'b0, div_q};
  assign done_o  = done_q;
  assign quot_o  = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? W'(shifted - {1'b0, div_q}) : shifted[W-1:0];
      quot_q <= {quot_q[W-2:0], ge};
    end
  end

endmodule

@@ rtl/cwp_checker.sv @@
// ----------------------------------------------------------------------------
// cwp_checker
// Port-level checks on the partitioner, bound to the top level.
// ----------------------------------------------------------------------------
`include "contiguous_weight_partitioner_defines.svh"

module cwp_checker
  import cwp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [PIDX_W-1:0]   part_index_o,
  input logic [CELL_W-1:0]   first_cell_o,
  input logic [CELL_W-1:0]   end_cell_o,
  input logic [LOAD_W-1:0]   part_load_o,
  input logic [STATUS_W-1:0] status_o,
  input logic                final_res_o
);

  logic [PIDX_W+2*CELL_W+LOAD_W+STATUS_W:0] out_word;

  assign out_word = {part_index_o, first_cell_o, end_cell_o, part_load_o,
                     status_o, final_res_o};

  // a stalled word stays and holds
  `CWP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `CWP_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word))

  // no weight is taken while a result is pending
  `CWP_ASSERT(a_busy_out, out_valid_o |-> in_stall_o)

  // an error word is always the run's only word
  `CWP_ASSERT(a_err_final, out_valid_o && status_o != STATUS_OK |-> final_res_o)

  // every part holds at least one cell
  `CWP_ASSERT(a_part_nonempty, out_valid_o && status_o == STATUS_OK |-> first_cell_o < end_cell_o)

endmodule

bind contiguous_weight_partitioner cwp_checker u_cwp_checker (.*);
